// ===== hdl/bfha_pkg.sv =====
`default_nettype none

package bfha_pkg;

    // heap geometry
    localparam int HEAP_BYTES = 4096;
    localparam int REGION     = HEAP_BYTES - (HEAP_BYTES % 8);
    localparam int WORDS      = HEAP_BYTES / 4;
    localparam int ADDR_W     = $clog2(WORDS);
    localparam int WORD_W     = 16;
    localparam int PAY_W      = 13;
    localparam int OFF_W      = 12;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_word END_OFF   = t_word'(REGION - 4);
    localparam t_word FTR0_OFF  = t_word'(REGION - 8);
    localparam t_word HDR0_OFF  = t_word'(4);
    localparam t_word HDR_BYTES = t_word'(4);
    localparam t_word MIN_BLK   = t_word'(8);
    localparam t_word A_BIT     = t_word'(1);
    localparam t_word P_BIT     = t_word'(2);
    localparam t_word TAIL_WORD = t_word'(1);
    localparam t_word SZ_MASK   = ~t_word'(3);
    localparam t_word ALN_MASK  = ~t_word'(7);
    localparam t_word ALN_ADD   = t_word'(7);

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT_HDR,
        OP_INIT_FTR,
        OP_INIT_END,
        OP_LOAD,
        OP_START,
        OP_WALK,
        OP_X_MARK,
        OP_TAKE,
        OP_RD_NX,
        OP_SET_P,
        OP_CLR_P,
        OP_ABSORB,
        OP_MERGE_PREV,
        OP_WR_HDR,
        OP_WR_FTR,
        OP_SP_HDR,
        OP_SP_FTR,
        OP_SP_REM,
        OP_OUT_OK,
        OP_OUT_FAIL
    } t_dp_op;

    typedef enum logic [4:0] {
        ST_INIT_HDR,
        ST_INIT_FTR,
        ST_INIT_END,
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_X_RD,
        ST_X_SET,
        ST_SP_HDR,
        ST_SP_FTR,
        ST_SP_REM,
        ST_F_RD,
        ST_F_ABS,
        ST_F_MERGE,
        ST_F_WH,
        ST_F_RD2,
        ST_F_CLR,
        ST_F_FTR,
        ST_OK,
        ST_FAIL
    } t_state;

    typedef struct packed {
        logic is_free;
        logic bad;
        logic stop;
        logic exact;
        logic found;
        logic h_alloc;
        logic best_valid;
        logic nx_lt_end;
        logic out_free;
    } t_dp_stat;

    function automatic t_addr word_idx(t_word off);
        return off[ADDR_W+1:2];
    endfunction

    // size of the block at cur, zero where a walk has to stop
    function automatic t_word blk_size(t_word cur, t_word h);
        t_word sz;
        sz = h & SZ_MASK;
        if (cur >= END_OFF || h == TAIL_WORD || sz < MIN_BLK || sz > END_OFF - cur) begin
            return '0;
        end
        return sz;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bfha_dp.sv =====
`default_nettype none

module bfha_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  var bfha_pkg::t_dp_op         i_op,
    input  wire                          i_req_type,
    input  wire [bfha_pkg::PAY_W-1:0]    i_payload_bytes,
    input  wire [bfha_pkg::OFF_W-1:0]    i_release_offset,
    input  wire                          i_m_tready,
    output bfha_pkg::t_dp_stat           o_stat,
    output logic                         o_m_tvalid,
    output logic                         o_fail,
    output logic [bfha_pkg::OFF_W-1:0]   o_payload_offset
);
    import bfha_pkg::*;

    t_word heap_mem [WORDS];

    // request
    logic  r_is_free;
    logic  r_bad;
    t_word r_need;
    t_word r_tgt;
    // walk
    t_word r_rd;
    t_word r_cur;
    t_word r_prev;
    logic  r_prev_p;
    t_word r_best;
    t_word r_best_sz;
    logic  r_best_p;
    logic  r_best_valid;
    // block being updated
    t_word r_hdr;
    t_word r_sz;
    logic  r_psz;
    t_word r_res;
    // result
    logic              r_out_valid;
    logic              r_fail;
    logic [OFF_W-1:0]  r_out_off;

    logic  mem_we;
    logic  mem_re;
    t_word mem_off;
    t_word mem_wdata;

    t_word w_sz;
    t_word w_nx;
    t_word w_rem;
    t_word w_rel;
    logic  w_better;
    logic  w_free_blk;
    logic  w_out_free;

    assign w_sz       = blk_size(r_cur, r_rd);
    assign w_nx       = r_hdr + r_sz;
    assign w_rem      = r_best_sz - r_need;
    assign w_rel      = t_word'(i_release_offset);
    assign w_free_blk = ~r_rd[0];
    assign w_better   = ~r_is_free & w_free_blk & (w_sz > r_need) & (w_sz < r_best_sz);
    assign w_out_free = ~r_out_valid | i_m_tready;

    always_comb begin
        o_stat.is_free    = r_is_free;
        o_stat.bad        = r_bad;
        o_stat.stop       = (w_sz == '0);
        o_stat.exact      = ~r_is_free & w_free_blk & (w_sz == r_need);
        o_stat.found      = r_is_free & (r_cur == r_tgt);
        o_stat.h_alloc    = r_rd[0];
        o_stat.best_valid = r_best_valid;
        o_stat.nx_lt_end  = (w_nx < END_OFF);
        o_stat.out_free   = w_out_free;
    end

    // memory port decode
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_off   = r_cur;
        mem_wdata = r_rd;
        case (i_op)
            OP_INIT_HDR: begin
                mem_we    = 1'b1;
                mem_off   = HDR0_OFF;
                mem_wdata = FTR0_OFF | P_BIT;
            end
            OP_INIT_FTR: begin
                mem_we    = 1'b1;
                mem_off   = FTR0_OFF;
                mem_wdata = FTR0_OFF;
            end
            OP_INIT_END: begin
                mem_we    = 1'b1;
                mem_off   = END_OFF;
                mem_wdata = TAIL_WORD;
            end
            OP_START: begin
                mem_re  = 1'b1;
                mem_off = HDR0_OFF;
            end
            OP_WALK: begin
                mem_re  = 1'b1;
                mem_off = r_cur + w_sz;
            end
            OP_X_MARK: begin
                mem_we    = 1'b1;
                mem_off   = r_cur;
                mem_wdata = r_rd | A_BIT;
            end
            OP_RD_NX: begin
                mem_re  = 1'b1;
                mem_off = w_nx;
            end
            OP_SET_P: begin
                mem_we    = 1'b1;
                mem_off   = w_nx;
                mem_wdata = r_rd | P_BIT;
            end
            OP_CLR_P: begin
                mem_we    = 1'b1;
                mem_off   = w_nx;
                mem_wdata = r_rd & ~P_BIT;
            end
            OP_WR_HDR: begin
                mem_we    = 1'b1;
                mem_off   = r_hdr;
                mem_wdata = r_sz | (r_psz ? P_BIT : '0);
            end
            OP_WR_FTR: begin
                mem_we    = 1'b1;
                mem_off   = w_nx - HDR_BYTES;
                mem_wdata = r_sz;
            end
            OP_SP_HDR: begin
                mem_we    = 1'b1;
                mem_off   = r_best;
                mem_wdata = r_need | (r_best_p ? P_BIT : '0) | A_BIT;
            end
            OP_SP_FTR: begin
                mem_we    = 1'b1;
                mem_off   = r_best + r_best_sz - HDR_BYTES;
                mem_wdata = w_rem;
            end
            OP_SP_REM: begin
                mem_we    = 1'b1;
                mem_off   = r_best + r_need;
                mem_wdata = w_rem | P_BIT;
            end
            default: begin
                mem_we = 1'b0;
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            heap_mem[word_idx(mem_off)] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= heap_mem[word_idx(mem_off)];
        end
    end

    // request, walk and block registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_is_free <= i_req_type;
                r_need    <= (t_word'(i_payload_bytes) + ALN_ADD + HDR_BYTES) & ALN_MASK;
                r_tgt     <= w_rel - HDR_BYTES;
                r_res     <= '0;
                if (i_req_type) begin
                    r_bad <= (i_release_offset[2:0] != 3'd0) || (w_rel < MIN_BLK)
                             || (w_rel >= END_OFF);
                end else begin
                    r_bad <= (i_payload_bytes == '0);
                end
            end
            OP_START: begin
                r_cur        <= HDR0_OFF;
                r_prev       <= '0;
                r_prev_p     <= 1'b0;
                r_best       <= '0;
                r_best_sz    <= '1;
                r_best_p     <= 1'b0;
                r_best_valid <= 1'b0;
            end
            OP_WALK: begin
                if (w_better) begin
                    r_best       <= r_cur;
                    r_best_sz    <= w_sz;
                    r_best_p     <= r_rd[1];
                    r_best_valid <= 1'b1;
                end
                r_prev   <= r_cur;
                r_prev_p <= r_rd[1];
                r_cur    <= r_cur + w_sz;
            end
            OP_X_MARK: begin
                r_hdr <= r_cur;
                r_sz  <= w_sz;
                r_res <= r_cur + HDR_BYTES;
            end
            OP_TAKE: begin
                r_hdr <= r_cur;
                r_sz  <= r_rd & SZ_MASK;
                r_psz <= r_rd[1];
            end
            OP_ABSORB: begin
                if (w_free_blk) begin
                    r_sz <= r_sz + blk_size(w_nx, r_rd);
                end
            end
            OP_MERGE_PREV: begin
                // previous block is free: grow it over the released one
                if (!r_psz && r_prev != '0) begin
                    r_sz  <= r_sz + (r_hdr - r_prev);
                    r_hdr <= r_prev;
                    r_psz <= r_prev_p;
                end
            end
            OP_SP_HDR: begin
                r_res <= r_best + HDR_BYTES;
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == OP_OUT_OK || i_op == OP_OUT_FAIL) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_OUT_OK) begin
            r_fail    <= 1'b0;
            r_out_off <= r_res[OFF_W-1:0];
        end else if (i_op == OP_OUT_FAIL) begin
            r_fail    <= 1'b1;
            r_out_off <= '0;
        end
    end

    assign o_m_tvalid       = r_out_valid;
    assign o_fail           = r_fail;
    assign o_payload_offset = r_out_off;

endmodule

`default_nettype wire

// ===== hdl/bfha_ctrl.sv =====
`default_nettype none

module bfha_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  var bfha_pkg::t_dp_stat i_stat,
    output bfha_pkg::t_dp_op    o_op
);
    import bfha_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT_HDR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT_HDR: n_state = ST_INIT_FTR;
            ST_INIT_FTR: n_state = ST_INIT_END;
            ST_INIT_END: n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: n_state = i_stat.bad ? ST_FAIL : ST_WALK;
            ST_WALK: begin
                if (i_stat.stop) begin
                    n_state = (!i_stat.is_free && i_stat.best_valid) ? ST_SP_HDR : ST_FAIL;
                end else if (i_stat.exact) begin
                    n_state = ST_X_RD;
                end else if (i_stat.found) begin
                    n_state = i_stat.h_alloc ? ST_F_RD : ST_FAIL;
                end
            end
            ST_X_RD:    n_state = i_stat.nx_lt_end ? ST_X_SET : ST_OK;
            ST_X_SET:   n_state = ST_OK;
            ST_SP_HDR:  n_state = ST_SP_FTR;
            ST_SP_FTR:  n_state = ST_SP_REM;
            ST_SP_REM:  n_state = ST_OK;
            ST_F_RD:    n_state = i_stat.nx_lt_end ? ST_F_ABS : ST_F_MERGE;
            ST_F_ABS:   n_state = ST_F_MERGE;
            ST_F_MERGE: n_state = ST_F_WH;
            ST_F_WH:    n_state = ST_F_RD2;
            ST_F_RD2:   n_state = i_stat.nx_lt_end ? ST_F_CLR : ST_F_FTR;
            ST_F_CLR:   n_state = ST_F_FTR;
            ST_F_FTR:   n_state = ST_OK;
            ST_OK, ST_FAIL: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_INIT_HDR;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_op       = OP_NONE;
        case (r_state)
            ST_INIT_HDR: o_op = OP_INIT_HDR;
            ST_INIT_FTR: o_op = OP_INIT_FTR;
            ST_INIT_END: o_op = OP_INIT_END;
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_op = OP_LOAD;
                end
            end
            ST_CHECK: begin
                if (!i_stat.bad) begin
                    o_op = OP_START;
                end
            end
            ST_WALK: begin
                if (i_stat.stop) begin
                    o_op = OP_NONE;
                end else if (i_stat.exact) begin
                    o_op = OP_X_MARK;
                end else if (i_stat.found) begin
                    o_op = OP_TAKE;
                end else begin
                    o_op = OP_WALK;
                end
            end
            ST_X_RD: begin
                if (i_stat.nx_lt_end) begin
                    o_op = OP_RD_NX;
                end
            end
            ST_X_SET:   o_op = OP_SET_P;
            ST_SP_HDR:  o_op = OP_SP_HDR;
            ST_SP_FTR:  o_op = OP_SP_FTR;
            ST_SP_REM:  o_op = OP_SP_REM;
            ST_F_RD: begin
                if (i_stat.nx_lt_end) begin
                    o_op = OP_RD_NX;
                end
            end
            ST_F_ABS:   o_op = OP_ABSORB;
            ST_F_MERGE: o_op = OP_MERGE_PREV;
            ST_F_WH:    o_op = OP_WR_HDR;
            ST_F_RD2: begin
                if (i_stat.nx_lt_end) begin
                    o_op = OP_RD_NX;
                end
            end
            ST_F_CLR:   o_op = OP_CLR_P;
            ST_F_FTR:   o_op = OP_WR_FTR;
            ST_OK: begin
                if (i_stat.out_free) begin
                    o_op = OP_OUT_OK;
                end
            end
            ST_FAIL: begin
                if (i_stat.out_free) begin
                    o_op = OP_OUT_FAIL;
                end
            end
            default: o_op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/best_fit_heap_allocator_top.sv =====
// walk: one block header is read per cycle; once the walk ends, the exact-fit, split or
//   merge steps update the heap and the result is registered; a result waits in ST_OK or
//   ST_FAIL while the receiver holds up the previous one
// throughput: one request in flight; the next is accepted the cycle after the result loads
// reset: synchronous, active low; afterwards the init states rebuild the single free block and end mark

`default_nettype none

module best_fit_heap_allocator_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request channel
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,   // payload_bytes[12:0], release_offset[24:13], zero pad
    input  wire  [0:0]  i_s_tuser,   // req_type[0]: 0 allocate, 1 free
    // result channel
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata,   // payload_offset[11:0], zero pad
    output logic [0:0]  o_m_tuser    // fail[0]
);
    import bfha_pkg::*;

    t_dp_op   op;
    t_dp_stat stat;

    logic             fail;
    logic [OFF_W-1:0] payload_offset;

    // controller: sequences the walk, split and merge steps
    bfha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_op       (op)
    );

    // datapath: header store, walk registers, result register
    bfha_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_req_type       (i_s_tuser[0]),
        .i_payload_bytes  (i_s_tdata[PAY_W-1:0]),
        .i_release_offset (i_s_tdata[PAY_W+OFF_W-1:PAY_W]),
        .i_m_tready       (i_m_tready),
        .o_stat           (stat),
        .o_m_tvalid       (o_m_tvalid),
        .o_fail           (fail),
        .o_payload_offset (payload_offset)
    );

    assign o_m_tdata = {{(16-OFF_W){1'b0}}, payload_offset};
    assign o_m_tuser = fail;

endmodule

`default_nettype wire
